// ----- hdl/rbrd_pkg.sv -----
`timescale 1ns / 1ps
package rbrd_pkg;

  localparam int MAX_PLANES  = 8;
  localparam int BYTE_W      = 8;
  localparam int ROW_W       = 7;
  localparam int PLANE_CNT_W = 4;
  localparam int PLANE_W     = 3;
  localparam int COUNT_W     = 7;
  localparam int COLUMN_W    = 6;
  localparam int GROUP_W     = 64;
  localparam int RUN_W       = 8;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE  = 2'd2;

  // packbits decode modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_LIT  = 2'd1;
  localparam logic [1:0] MODE_REP  = 2'd2;
  localparam logic [1:0] MODE_SKIP = 2'd3;

  localparam logic [BYTE_W-1:0] CMD_NOP = 8'd128;
  localparam logic [8:0]        REP_BASE = 9'd257;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } rbrd_req_t;

  typedef struct packed {
    logic               busy;
    logic [ROW_W-1:0]   col;
  } rbrd_stat_t;

  // bit 7-k of the plane byte goes to bit p of pixel k
  function automatic logic [GROUP_W-1:0] spread_plane(input logic [BYTE_W-1:0] b,
                                                      input logic [PLANE_W-1:0] p);
    logic [GROUP_W-1:0] g;
    g = '0;
    for (int k = 0; k < 8; k++) begin
      g[8*k] = b[7-k];
    end
    return g << p;
  endfunction

endpackage

// ----- hdl/rbrd_if.sv -----
`timescale 1ns / 1ps
interface rbrd_in_if;
  import rbrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rbrd_out_if;
  import rbrd_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] column;
  logic [GROUP_W-1:0]  pixel_group;
  logic                row_end;
  logic                last_of_run;
  modport source (output valid, output column, output pixel_group, output row_end,
                  output last_of_run, input ready);
  modport sink (input valid, input column, input pixel_group, input row_end,
                input last_of_run, output ready);
endinterface

// ----- hdl/rbrd_column_unit.sv -----
`timescale 1ns / 1ps
module rbrd_column_unit #(
  parameter int MAX_ROW_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  rbrd_pkg::rbrd_req_t             req,
  input  logic [rbrd_pkg::ROW_W-1:0]      rows,
  input  logic [rbrd_pkg::PLANE_CNT_W-1:0] planes,
  output rbrd_pkg::rbrd_stat_t            stat,
  rbrd_out_if.source                      pixels_out
);
  import rbrd_pkg::*;

  localparam int SLOT_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]         state;
  logic [BYTE_W-1:0]  bval;
  logic [COUNT_W-1:0] cnt_left;
  logic [ROW_W-1:0]   col;
  logic [PLANE_W-1:0] plane;
  logic [GROUP_W-1:0] rdata;

  logic [GROUP_W-1:0] line_mem [MAX_ROW_BYTES];

  logic                out_valid;
  logic [COLUMN_W-1:0] out_column;
  logic [GROUP_W-1:0]  out_group;
  logic                out_row_end;
  logic                out_last;

  logic [SLOT_W-1:0]  slot;
  logic               last_plane;
  logic               row_end;
  logic               emit;
  logic               wr_go;
  logic [GROUP_W-1:0] merged;

  assign slot = (col < ROW_W'(MAX_ROW_BYTES)) ? col[SLOT_W-1:0] : SLOT_W'(MAX_ROW_BYTES - 1);
  assign last_plane = ({1'b0, plane} + 4'd1) >= planes;
  assign row_end = ({1'b0, col} + 8'd1) >= {1'b0, rows};
  assign emit = last_plane;
  // a column of the last plane needs the output register free
  assign wr_go = (state == ST_WR) && (!emit || !out_valid || pixels_out.ready);
  assign merged = (plane == '0) ? spread_plane(bval, plane)
                                : (rdata | spread_plane(bval, plane));

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      rdata <= line_mem[slot];
    end
    if (wr_go) begin
      line_mem[slot] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      plane <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && req.count != '0) begin
            bval     <= req.data;
            cnt_left <= req.count;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (wr_go) begin
            if (row_end) begin
              col   <= '0;
              plane <= last_plane ? '0 : plane + 3'd1;
            end else begin
              col <= col + 7'd1;
            end
            cnt_left <= cnt_left - 7'd1;
            state    <= (cnt_left == 7'd1) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_go && emit) begin
      out_valid <= 1'b1;
    end else if (pixels_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go && emit) begin
      out_column  <= col[COLUMN_W-1:0];
      out_group   <= merged;
      out_row_end <= row_end;
      out_last    <= (cnt_left == 7'd1);
    end
  end

  assign pixels_out.valid       = out_valid;
  assign pixels_out.column      = out_column;
  assign pixels_out.pixel_group = out_group;
  assign pixels_out.row_end     = out_row_end;
  assign pixels_out.last_of_run = out_last;

  assign stat.busy  = (state != ST_IDLE);
  assign stat.col   = col;

endmodule

// ----- hdl/rle_bitplane_row_decoder_top.sv -----
`timescale 1ns / 1ps
// channel     dir  payload                                         handshake
// data_in     in   data_byte[7:0]                                  valid/ready
// pixels_out  out  column[5:0] pixel_group[63:0] row_end last_of_run valid/ready
//
// a command byte or a skipped literal is only accepted; a plane byte is accepted, then
// read from the line store, then modified and written back; a repeat value byte repeats
// the one-port read then write of the line store for each of its columns.
// rst is synchronous; it clears the decoder state and loads the register defaults.
// the line store is not cleared. a full output register stalls only a column write
// of the last plane; data_in is ready whenever no column work is pending.
module rle_bitplane_row_decoder_top #(
  parameter int MAX_ROW_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [rbrd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rbrd_pkg::ROW_W-1:0]    wr_data,
  rbrd_in_if.sink                       data_in,
  rbrd_out_if.source                    pixels_out
);
  import rbrd_pkg::*;

  logic [ROW_W-1:0]       row_bytes;
  logic [PLANE_CNT_W-1:0] plane_count;
  logic                   rle_enable;

  logic [1:0]       mode, mode_next;
  logic [RUN_W-1:0] run_left, run_left_next;

  logic [ROW_W-1:0]       rows;
  logic [PLANE_CNT_W-1:0] planes;
  rbrd_req_t              req;
  rbrd_stat_t             stat;
  logic                   accept;
  logic                   start;
  logic [RUN_W-1:0]       run_dec;
  logic [ROW_W-1:0]       rem;
  logic                   lit_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= 7'd40;
      plane_count <= 4'd5;
      rle_enable  <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW_BYTES:   row_bytes   <= wr_data;
        REG_PLANE_COUNT: plane_count <= wr_data[PLANE_CNT_W-1:0];
        REG_RLE_ENABLE:  rle_enable  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign rows = (row_bytes == '0) ? 7'd1 :
                (row_bytes > ROW_W'(MAX_ROW_BYTES)) ? ROW_W'(MAX_ROW_BYTES) : row_bytes;
  assign planes = (plane_count == '0) ? 4'd1 :
                  (plane_count > PLANE_CNT_W'(MAX_PLANES)) ? PLANE_CNT_W'(MAX_PLANES)
                                                           : plane_count;

  assign data_in.ready = !stat.busy;
  assign accept = data_in.valid && data_in.ready;

  assign run_dec  = (run_left != '0) ? run_left - 8'd1 : run_left;
  assign rem      = (stat.col < rows) ? rows - stat.col : 7'd1;
  assign lit_done = ({1'b0, stat.col} + 8'd1) >= {1'b0, rows};

  always_comb begin
    mode_next     = mode;
    run_left_next = run_left;
    start         = 1'b0;
    req.data      = data_in.data_byte;
    req.count     = 7'd1;
    if (accept) begin
      if (!rle_enable) begin
        mode_next     = MODE_CMD;
        run_left_next = '0;
        start         = 1'b1;
      end else begin
        case (mode)
          MODE_LIT: begin
            run_left_next = run_dec;
            start         = 1'b1;
            if (run_dec == '0) begin
              mode_next = MODE_CMD;
            end else if (lit_done) begin
              mode_next = MODE_SKIP;
            end
          end
          MODE_SKIP: begin
            run_left_next = run_dec;
            if (run_dec == '0) begin
              mode_next = MODE_CMD;
            end
          end
          MODE_REP: begin
            // repeat count clamped to the columns left in the plane
            req.count     = ({1'b0, run_left} > {2'b0, rem}) ? rem : run_left[ROW_W-1:0];
            start         = 1'b1;
            mode_next     = MODE_CMD;
            run_left_next = '0;
          end
          default: begin
            if (data_in.data_byte < CMD_NOP) begin
              mode_next     = MODE_LIT;
              run_left_next = data_in.data_byte + 8'd1;
            end else if (data_in.data_byte > CMD_NOP) begin
              mode_next     = MODE_REP;
              run_left_next = RUN_W'(REP_BASE - {1'b0, data_in.data_byte});
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_CMD;
      run_left <= '0;
    end else begin
      mode     <= mode_next;
      run_left <= run_left_next;
    end
  end

  rbrd_column_unit #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_column (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .rows      (rows),
    .planes    (planes),
    .stat      (stat),
    .pixels_out(pixels_out)
  );

endmodule

// ----- hdl/rbrd_checker.sv -----
`timescale 1ns / 1ps
module rbrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_group,
  input logic        out_last
);

  // a held word keeps its pixels
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_group))
    else $error("held output word changed");

  // a word of an unfinished run means column work is still pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a run is unfinished");

  // no word can appear in the cycle after a byte is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("output word too early after accept");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rle_bitplane_row_decoder_top rbrd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (data_in.valid),
  .in_ready (data_in.ready),
  .out_valid(pixels_out.valid),
  .out_ready(pixels_out.ready),
  .out_group(pixels_out.pixel_group),
  .out_last (pixels_out.last_of_run)
);

// ----- test/rle_bitplane_row_decoder_top_tb.sv -----
`timescale 1ns / 1ps
module rle_bitplane_row_decoder_top_tb;
  import rbrd_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_TARGET   = 380;
  localparam int LIMIT_NS      = 20_000_000;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [GROUP_W-1:0]  pixel_group;
    logic                row_end;
    logic                last_of_run;
  } pixel_word_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [ROW_W-1:0]     wr_data;

  rbrd_in_if  in_ch ();
  rbrd_out_if out_ch ();

  rle_bitplane_row_decoder_top uut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .data_in    (in_ch),
    .pixels_out (out_ch)
  );

  // shadow of the decoder
  logic [GROUP_W-1:0]     line_shadow [0:63];
  logic [ROW_W-1:0]       col_at;
  logic [PLANE_W-1:0]     plane_at;
  logic [1:0]             mode_at;
  int                     run_count;
  logic [ROW_W-1:0]       row_bytes_reg;
  logic [PLANE_CNT_W-1:0] planes_reg;
  logic                   rle_reg;

  pixel_word_t pixel_words_due [$];
  pixel_word_t step_words [$];
  pixel_word_t due_word;

  int rows_done;
  int items_sent;
  int mismatch_count;
  bit calm;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("[rle_bitplane_row_decoder_top] ERROR");
    $finish;
  end

  function automatic int row_len();
    if (row_bytes_reg < 1) return 1;
    if (row_bytes_reg > 64) return 64;
    return int'(row_bytes_reg);
  endfunction

  function automatic int plane_total();
    if (planes_reg < 1) return 1;
    if (planes_reg > MAX_PLANES) return MAX_PLANES;
    return int'(planes_reg);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  // one plane byte into the current column; emits it on the last plane
  task automatic write_column(input logic [BYTE_W-1:0] b, output bit plane_done);
    int                 rl;
    int                 pc;
    int                 slot;
    logic [GROUP_W-1:0] g;
    bit                 last;
    bit                 rend;
    pixel_word_t        w;
    rl = row_len();
    pc = plane_total();
    slot = (col_at < 64) ? int'(col_at) : 63;
    g = '0;
    for (int k = 0; k < 8; k++) g[8*k] = b[7-k];
    if (plane_at == 0) line_shadow[slot] = g;
    else line_shadow[slot] = line_shadow[slot] | (g << plane_at);
    last = (int'(plane_at) + 1 >= pc);
    rend = (int'(col_at) + 1 >= rl);
    if (last) begin
      w.column      = col_at[COLUMN_W-1:0];
      w.pixel_group = line_shadow[slot];
      w.row_end     = rend;
      w.last_of_run = 1'b0;
      step_words.push_back(w);
    end
    plane_done = rend;
    if (rend) begin
      col_at = '0;
      if (last) begin
        plane_at = '0;
        rows_done++;
      end else begin
        plane_at = plane_at + 1'b1;
      end
    end else begin
      col_at = col_at + 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    bit done;
    int rem;
    int cnt;
    step_words.delete();
    if (!rle_reg) begin
      mode_at = MODE_CMD;
      run_count = 0;
      write_column(b, done);
    end else begin
      case (mode_at)
        MODE_LIT: begin
          if (run_count > 0) run_count--;
          write_column(b, done);
          if (run_count == 0) mode_at = MODE_CMD;
          else if (done) mode_at = MODE_SKIP;
        end
        MODE_SKIP: begin
          if (run_count > 0) run_count--;
          if (run_count == 0) mode_at = MODE_CMD;
        end
        MODE_REP: begin
          // repeat is cut at the row end, value byte used once
          rem = (int'(col_at) < row_len()) ? row_len() - int'(col_at) : 1;
          cnt = (run_count < rem) ? run_count : rem;
          repeat (cnt) write_column(b, done);
          mode_at = MODE_CMD;
          run_count = 0;
        end
        default: begin
          if (b < CMD_NOP) begin
            mode_at = MODE_LIT;
            run_count = int'(b) + 1;
          end else if (b > CMD_NOP) begin
            mode_at = MODE_REP;
            run_count = int'(REP_BASE) - int'(b);
          end
        end
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last_of_run = 1'b1;
    foreach (step_words[i]) pixel_words_due.push_back(step_words[i]);
  endtask

  // mostly well-formed packbits runs sized to the columns left, some overshoot and noise
  function automatic logic [BYTE_W-1:0] pick_body_byte();
    int rem;
    int c;
    int r;
    if (!rle_reg || mode_at != MODE_CMD) return 8'($urandom_range(0, 255));
    rem = row_len() - int'(col_at);
    if (rem < 1) rem = 1;
    r = $urandom_range(0, 99);
    if (r < 4) return CMD_NOP;
    if (r < 7) return 8'($urandom_range(0, 255));
    c = ($urandom_range(0, 7) == 0) ? rem + $urandom_range(1, 3) : $urandom_range(1, rem);
    if (r < 45) begin
      if (c > 128) c = 128;
      return 8'(c - 1);
    end
    if (c < 2) c = 2;
    if (c > 128) c = 128;
    return 8'(257 - c);
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (!(rle_reg && (mode_at == MODE_SKIP || (mode_at == MODE_CMD && b == CMD_NOP))))
      items_sent++;
    decode_byte(b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pixel_words_due.size() != 0) @(posedge clk);
    // a repeat into a non-final plane runs on with nothing to show
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int rb, input int pc, input int rle);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_ROW_BYTES;
    wr_data  <= ROW_W'(rb);
    @(negedge clk);
    wr_index <= REG_PLANE_COUNT;
    wr_data  <= ROW_W'(pc);
    @(negedge clk);
    wr_index <= REG_RLE_ENABLE;
    wr_data  <= ROW_W'(rle);
    @(negedge clk);
    wr_en <= 1'b0;
    row_bytes_reg = ROW_W'(rb);
    planes_reg    = PLANE_CNT_W'(pc);
    rle_reg       = rle[0];
  endtask

  task automatic run_rows(input int n);
    int target;
    target = rows_done + n;
    while (rows_done < target || (rle_reg && mode_at != MODE_CMD))
      send_word(pick_body_byte());
  endtask

  task automatic test_packbits_commands();
    logic [BYTE_W-1:0] seq [$];
    set_config(4, 1, 1);
    // nop, single literal, literal run cut at row end, repeat cut at row end
    seq = '{8'h80, 8'h00, 8'hFF, 8'h80, 8'h03, 8'h00, 8'hA5, 8'h5A, 8'h7F,
            8'h82, 8'hC3};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic test_clamped_long_repeat();
    wait_idle();
    // row length above the limit, longest repeat
    set_config(127, 1, 1);
    send_word(8'h81);
    send_word(8'h5A);
  endtask

  task automatic test_raw_planes();
    logic [BYTE_W-1:0] seq [$];
    // leave a literal open, raw mode must drop it
    send_word(8'h02);
    wait_idle();
    set_config(0, 15, 0);
    seq = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic test_shrink_mid_row();
    logic [BYTE_W-1:0] seq [$];
    wait_idle();
    set_config(3, 3, 0);
    seq = '{8'h12, 8'h34, 8'h56, 8'h9C};
    foreach (seq[i]) send_word(seq[i]);
    // column now past the new row limit
    wait_idle();
    set_config(1, 2, 0);
    send_word(8'hE7);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_config(16, 1, 1);
    hold_request = 1'b1;
    run_rows(2);
  endtask

  task automatic test_random_streams();
    int rb;
    int pc;
    int rle;
    int n;
    while (items_sent < ITEM_TARGET - 40) begin
      if ($urandom_range(0, 7) == 0) begin
        rb = 64;
        pc = $urandom_range(1, 2);
        rle = 1;
        n = 1;
      end else begin
        rb = $urandom_range(1, 8);
        pc = $urandom_range(1, 8);
        rle = ($urandom_range(0, 3) != 0) ? 1 : 0;
        n = rle ? $urandom_range(1, 3) : 1;
      end
      wait_idle();
      set_config(rb, pc, rle);
      run_rows(n);
    end
  endtask

  task automatic test_quiet_tail();
    wait_idle();
    calm = 1'b1;
    set_config($urandom_range(1, 8), $urandom_range(1, 4), 1);
    run_rows(2);
  endtask

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (int stall_left = HOLD_CYCLES - 1; stall_left > 0; stall_left--) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pixel_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word at column %0d", out_ch.column));
      end else begin
        due_word = pixel_words_due.pop_front();
        if (out_ch.column !== due_word.column)
          report_mismatch($sformatf("column %0d, want %0d", out_ch.column, due_word.column));
        if (out_ch.pixel_group !== due_word.pixel_group)
          report_mismatch($sformatf("column %0d pixel_group %h, want %h", due_word.column,
                                    out_ch.pixel_group, due_word.pixel_group));
        if (out_ch.row_end !== due_word.row_end)
          report_mismatch($sformatf("column %0d row_end %b, want %b", due_word.column,
                                    out_ch.row_end, due_word.row_end));
        if (out_ch.last_of_run !== due_word.last_of_run)
          report_mismatch($sformatf("column %0d last_of_run %b, want %b", due_word.column,
                                    out_ch.last_of_run, due_word.last_of_run));
      end
    end
  end

  initial begin
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = REG_ROW_BYTES;
    wr_data         = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    calm            = 1'b0;
    hold_request    = 1'b0;
    rows_done       = 0;
    items_sent      = 0;
    mismatch_count  = 0;
    col_at          = '0;
    plane_at        = '0;
    mode_at         = MODE_CMD;
    run_count       = 0;
    row_bytes_reg   = 7'd40;
    planes_reg      = 4'd5;
    rle_reg         = 1'b1;
    for (int i = 0; i < 64; i++) line_shadow[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_packbits_commands();
    test_clamped_long_repeat();
    test_raw_planes();
    test_shrink_mid_row();
    test_output_backpressure();
    test_random_streams();
    test_quiet_tail();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("[rle_bitplane_row_decoder_top] OK");
    end else begin
      $display("[rle_bitplane_row_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
